[hdl/accel_hand_motion_integrator_defines.svh]
// Assertion macros shared by the checkers of the hand motion integrator.
// Stand-alone header; it needs no other file.
`ifndef ACCEL_HAND_MOTION_INTEGRATOR_DEFINES_SVH
`define ACCEL_HAND_MOTION_INTEGRATOR_DEFINES_SVH

// General property check, disabled while reset is held.
`define AHMI_ASSERT(name, clk, rst_n, prop) \
    name: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("%m: property failed");

// A signal holds its value in the cycle after a condition.
`define AHMI_ASSERT_HOLD(name, clk, rst_n, cond, sig) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> $stable(sig)) \
        else $error("%m: signal did not hold");

`endif

[hdl/ahmi_pkg.sv]
// Shared constants and types of the hand motion integrator.
// Has no dependencies; the input interface, lanes, merging stage and top level use it.
`default_nettype none

package ahmi_pkg;

    localparam int AXES        = 3;
    localparam int SAMPLE_W    = 12;
    localparam int DEADBAND_W  = 12;
    localparam int GAIN_W      = 16;
    localparam int FACTOR_W    = 17;
    localparam int FACTOR_BITS = 16;

    localparam logic [FACTOR_W-1:0] FACTOR_ONE = 17'h10000;

    // Configuration port.
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 17;

    localparam logic [CFG_IDX_W-1:0] CFG_DEADBAND  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_STEP_GAIN = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_DAMPING   = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_RETENTION = 2'd3;

    localparam logic [DEADBAND_W-1:0] DEADBAND_RST  = 12'd154;
    localparam logic [GAIN_W-1:0]     STEP_GAIN_RST = 16'd82;
    localparam logic [FACTOR_W-1:0]   DAMPING_RST   = 17'd62259;
    localparam logic [FACTOR_W-1:0]   RETENTION_RST = 17'd64881;

    // Control from the sequencer to a lane, and status back.
    typedef struct packed {
        logic start;
        logic ack;
    } t_lane_ctrl;

    typedef struct packed {
        logic idle;
        logic done;
    } t_lane_stat;

endpackage

`default_nettype wire

[hdl/ahmi_in_if.sv]
// Input channel of the hand motion integrator: one three-axis sample per word.
// Uses ahmi_pkg for the sample width.
`default_nettype none

interface ahmi_in_if;
    logic                                    valid;
    logic                                    ready;
    logic signed [ahmi_pkg::SAMPLE_W-1:0]    sample_x;
    logic signed [ahmi_pkg::SAMPLE_W-1:0]    sample_y;
    logic signed [ahmi_pkg::SAMPLE_W-1:0]    sample_z;

    modport source (output valid, sample_x, sample_y, sample_z, input ready);
    modport sink   (input valid, sample_x, sample_y, sample_z, output ready);
endinterface

`default_nettype wire

[hdl/ahmi_out_if.sv]
// Output channel of the hand motion integrator: three positions per word.
// Stand-alone; the position width is a parameter of the interface.
`default_nettype none

interface ahmi_out_if #(
    parameter int WIDTH = 40
);
    logic                    valid;
    logic                    ready;
    logic signed [WIDTH-1:0] pos_x;
    logic signed [WIDTH-1:0] pos_y;
    logic signed [WIDTH-1:0] pos_z;

    modport source (output valid, pos_x, pos_y, pos_z, input ready);
    modport sink   (input valid, pos_x, pos_y, pos_z, output ready);
endinterface

`default_nettype wire

[hdl/ahmi_lane.sv]
// One axis lane: deadband, velocity and position update with saturation and scaling.
// Uses ahmi_pkg for widths, factor constants and the lane control structs.
`default_nettype none

module ahmi_lane #(
    parameter int FRAC_BITS   = 16,
    parameter int STATE_WIDTH = 40
) (
    input  wire  logic                                   i_clk,
    input  wire  logic                                   i_rst_n,
    input  wire  ahmi_pkg::t_lane_ctrl                   i_ctrl,
    input  wire  logic signed [ahmi_pkg::SAMPLE_W-1:0]   i_sample,
    input  wire  logic [ahmi_pkg::DEADBAND_W-1:0]        i_deadband,
    input  wire  logic [ahmi_pkg::GAIN_W-1:0]            i_gain,
    input  wire  logic [ahmi_pkg::FACTOR_W-1:0]          i_damping,
    input  wire  logic [ahmi_pkg::FACTOR_W-1:0]          i_retention,
    output       ahmi_pkg::t_lane_stat                   o_stat,
    output       logic signed [STATE_WIDTH-1:0]          o_pos
);

    localparam int DIFF_W = ahmi_pkg::SAMPLE_W + 1;
    localparam int PROD_W = DIFF_W + ahmi_pkg::GAIN_W + 1;
    localparam int UP     = FRAC_BITS - ahmi_pkg::FACTOR_BITS;
    localparam int SH_L   = (UP > 0) ? UP : 0;
    localparam int SH_R   = (UP < 0) ? -UP : 0;
    localparam int INC_W  = PROD_W + SH_L;
    localparam int SUM_W  = ((STATE_WIDTH > INC_W) ? STATE_WIDTH : INC_W) + 1;
    localparam int LO_W   = (STATE_WIDTH + 1) / 2;
    localparam int HI_W   = STATE_WIDTH - LO_W;
    localparam int FAC_W  = ahmi_pkg::FACTOR_W;
    localparam int PLO_W  = LO_W + FAC_W;
    localparam int PHI_W  = HI_W + FAC_W + 1;
    localparam int FULL_W = STATE_WIDTH + FAC_W + 1;
    localparam int TOP_W  = SUM_W - STATE_WIDTH + 1;

    localparam logic [3:0] ST_IDLE = 4'd0;
    localparam logic [3:0] ST_INC  = 4'd1;
    localparam logic [3:0] ST_VSUM = 4'd2;
    localparam logic [3:0] ST_VLO  = 4'd3;
    localparam logic [3:0] ST_VHI  = 4'd4;
    localparam logic [3:0] ST_VFIN = 4'd5;
    localparam logic [3:0] ST_PSUM = 4'd6;
    localparam logic [3:0] ST_PLO  = 4'd7;
    localparam logic [3:0] ST_PHI  = 4'd8;
    localparam logic [3:0] ST_PFIN = 4'd9;
    localparam logic [3:0] ST_DONE = 4'd10;

    localparam logic signed [STATE_WIDTH-1:0] ST_MAX = {1'b0, {(STATE_WIDTH-1){1'b1}}};
    localparam logic signed [STATE_WIDTH-1:0] ST_MIN = {1'b1, {(STATE_WIDTH-1){1'b0}}};

    logic [3:0]                      r_step, n_step;
    logic signed [ahmi_pkg::SAMPLE_W-1:0] r_prev;
    logic signed [DIFF_W-1:0]        r_d;
    logic signed [INC_W-1:0]         r_inc;
    logic signed [STATE_WIDTH-1:0]   r_acc;
    logic [PLO_W-1:0]                r_plo;
    logic signed [PHI_W-1:0]         r_phi;
    logic signed [STATE_WIDTH-1:0]   r_vel;
    logic signed [STATE_WIDTH-1:0]   r_pos;

    logic signed [DIFF_W-1:0]        diff;
    logic [DIFF_W-1:0]               mag;
    logic signed [PROD_W-1:0]        prod;
    logic signed [INC_W-1:0]         inc_al;
    logic signed [SUM_W-1:0]         add_a, add_b, sum;
    logic [TOP_W-1:0]                sum_top;
    logic signed [STATE_WIDTH-1:0]   sat;
    logic [FAC_W-1:0]                damp_c, keep_c, fac;
    logic [FULL_W-1:0]               full;
    logic signed [STATE_WIDTH-1:0]   scaled;

    // Change from the previous sample, zeroed inside the deadband.
    assign diff = DIFF_W'(i_sample) - DIFF_W'(r_prev);
    assign mag  = diff[DIFF_W-1] ? DIFF_W'(-diff) : DIFF_W'(diff);

    // Increment: change times the step gain, aligned to the state fraction.
    assign prod   = PROD_W'(r_d) * PROD_W'($signed({1'b0, i_gain}));
    assign inc_al = (INC_W'(prod) <<< SH_L) >>> SH_R;

    // One saturating adder serves both the velocity and the position sum.
    always_comb begin
        if (r_step == ST_VSUM) begin
            add_a = SUM_W'(r_vel);
            add_b = SUM_W'(r_inc);
        end else begin
            add_a = SUM_W'(r_pos);
            add_b = SUM_W'(r_vel);
        end
        sum     = add_a + add_b;
        sum_top = sum[SUM_W-1:STATE_WIDTH-1];
        if ((&sum_top) || !(|sum_top)) begin
            sat = sum[STATE_WIDTH-1:0];
        end else if (sum[SUM_W-1]) begin
            sat = ST_MIN;
        end else begin
            sat = ST_MAX;
        end
    end

    // Factors above one are used as exactly one.
    assign damp_c = (i_damping > ahmi_pkg::FACTOR_ONE) ? ahmi_pkg::FACTOR_ONE : i_damping;
    assign keep_c = (i_retention > ahmi_pkg::FACTOR_ONE) ? ahmi_pkg::FACTOR_ONE : i_retention;
    assign fac    = (r_step == ST_VLO || r_step == ST_VHI) ? damp_c : keep_c;

    // Scaling is done as two registered partial products, low half then high half, then recombined.
    assign full   = (FULL_W'(r_phi) << LO_W) + FULL_W'(r_plo);
    assign scaled = full[ahmi_pkg::FACTOR_BITS +: STATE_WIDTH];

    always_comb begin
        n_step = r_step;
        case (r_step)
            ST_IDLE: begin
                if (i_ctrl.start) begin
                    n_step = ST_INC;
                end
            end
            ST_INC:  n_step = ST_VSUM;
            ST_VSUM: n_step = ST_VLO;
            ST_VLO:  n_step = ST_VHI;
            ST_VHI:  n_step = ST_VFIN;
            ST_VFIN: n_step = ST_PSUM;
            ST_PSUM: n_step = ST_PLO;
            ST_PLO:  n_step = ST_PHI;
            ST_PHI:  n_step = ST_PFIN;
            ST_PFIN: n_step = ST_DONE;
            ST_DONE: begin
                if (i_ctrl.ack) begin
                    n_step = ST_IDLE;
                end
            end
            default: n_step = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step <= ST_IDLE;
            r_prev <= '0;
            r_vel  <= '0;
            r_pos  <= '0;
        end else begin
            r_step <= n_step;
            if (r_step == ST_IDLE && i_ctrl.start) begin
                r_prev <= i_sample;
            end
            if (r_step == ST_VFIN) begin
                r_vel <= scaled;
            end
            if (r_step == ST_PFIN) begin
                r_pos <= scaled;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_step == ST_IDLE && i_ctrl.start) begin
            r_d <= (mag < DIFF_W'(i_deadband)) ? '0 : diff;
        end
        if (r_step == ST_INC) begin
            r_inc <= inc_al;
        end
        if (r_step == ST_VSUM || r_step == ST_PSUM) begin
            r_acc <= sat;
        end
        if (r_step == ST_VLO || r_step == ST_PLO) begin
            r_plo <= PLO_W'(r_acc[LO_W-1:0]) * PLO_W'(fac);
        end
        if (r_step == ST_VHI || r_step == ST_PHI) begin
            r_phi <= PHI_W'($signed(r_acc[STATE_WIDTH-1:LO_W])) * PHI_W'($signed({1'b0, fac}));
        end
    end

    assign o_stat.idle = (r_step == ST_IDLE);
    assign o_stat.done = (r_step == ST_DONE);
    assign o_pos       = r_pos;

endmodule

`default_nettype wire

[hdl/ahmi_merge.sv]
// Merging stage: gathers the three lane positions into the output word register.
// Uses ahmi_pkg for the lane status struct and ahmi_out_if for the channel.
`default_nettype none

module ahmi_merge #(
    parameter int STATE_WIDTH = 40
) (
    input  wire  logic                           i_clk,
    input  wire  logic                           i_rst_n,
    input  wire  ahmi_pkg::t_lane_stat           i_stat [ahmi_pkg::AXES],
    input  wire  logic signed [STATE_WIDTH-1:0]  i_pos  [ahmi_pkg::AXES],
    output       logic                           o_ack,
    ahmi_out_if.source                           o_res
);

    logic                           r_valid;
    logic signed [STATE_WIDTH-1:0]  r_pos_x, r_pos_y, r_pos_z;
    logic                           all_done;
    logic                           load;

    assign all_done = i_stat[0].done && i_stat[1].done && i_stat[2].done;
    // The register takes a new word when it is empty or being emptied.
    assign load     = all_done && (!r_valid || o_res.ready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (load) begin
            r_valid <= 1'b1;
        end else if (o_res.ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_pos_x <= i_pos[0];
            r_pos_y <= i_pos[1];
            r_pos_z <= i_pos[2];
        end
    end

    assign o_ack       = load;
    assign o_res.valid = r_valid;
    assign o_res.pos_x = r_pos_x;
    assign o_res.pos_y = r_pos_y;
    assign o_res.pos_z = r_pos_z;

endmodule

`default_nettype wire

[hdl/accel_hand_motion_integrator.sv]
// Top level of the three-axis hand motion integrator.
// Uses ahmi_pkg, ahmi_in_if, ahmi_out_if, ahmi_lane and ahmi_merge.
`default_nettype none

// The block takes one accelerometer word (three signed 12-bit axes, 1024
// counts per g) and returns one word of three positions for it. Each axis has
// its own lane: the change from the previous sample is zeroed inside the
// deadband, scaled by the step gain and added to the velocity, which is then
// damped; the velocity is added to the position, which is then scaled by the
// retention factor. Both sums saturate to the signed STATE_WIDTH range and
// every scaling is a product with a Q1.16 factor truncated toward minus
// infinity; a factor above one is used as one. The state keeps FRAC_BITS
// fraction bits. A word is taken only when every lane is idle: each lane
// walks through ten steps, because the 40-bit by 17-bit scaling product is
// built from two half-width partial products in separate cycles, once for
// the velocity and once for the position, and the result then moves into the
// output register. The output register lets the lanes take the next word as
// soon as the previous result has been loaded, even while it still waits to
// be taken. Configuration writes should be made only while the block is idle.
// Lane step, last sample, velocity and position and the output valid flag
// clear on reset, settings take reset values; there is no clearing pass.

module accel_hand_motion_integrator #(
    parameter int FRAC_BITS   = 16,
    parameter int STATE_WIDTH = 40
) (
    input  wire  logic                                  i_clk,
    input  wire  logic                                  i_rst_n,
    ahmi_in_if.sink                                     i_smp,
    ahmi_out_if.source                                  o_res,
    input  wire  logic                                  i_cfg_we,
    input  wire  logic [ahmi_pkg::CFG_IDX_W-1:0]        i_cfg_idx,
    input  wire  logic [ahmi_pkg::CFG_DATA_W-1:0]       i_cfg_data
);

    // Configuration registers.
    logic [ahmi_pkg::DEADBAND_W-1:0] r_deadband;
    logic [ahmi_pkg::GAIN_W-1:0]     r_gain;
    logic [ahmi_pkg::FACTOR_W-1:0]   r_damping;
    logic [ahmi_pkg::FACTOR_W-1:0]   r_retention;

    ahmi_pkg::t_lane_ctrl            lane_ctrl;
    ahmi_pkg::t_lane_stat            lane_stat [ahmi_pkg::AXES];
    logic signed [STATE_WIDTH-1:0]   lane_pos  [ahmi_pkg::AXES];
    logic signed [ahmi_pkg::SAMPLE_W-1:0] lane_sample [ahmi_pkg::AXES];
    logic                            ack;
    logic                            accept;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_deadband  <= ahmi_pkg::DEADBAND_RST;
            r_gain      <= ahmi_pkg::STEP_GAIN_RST;
            r_damping   <= ahmi_pkg::DAMPING_RST;
            r_retention <= ahmi_pkg::RETENTION_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                ahmi_pkg::CFG_DEADBAND:  r_deadband  <= i_cfg_data[ahmi_pkg::DEADBAND_W-1:0];
                ahmi_pkg::CFG_STEP_GAIN: r_gain      <= i_cfg_data[ahmi_pkg::GAIN_W-1:0];
                ahmi_pkg::CFG_DAMPING:   r_damping   <= i_cfg_data[ahmi_pkg::FACTOR_W-1:0];
                ahmi_pkg::CFG_RETENTION: r_retention <= i_cfg_data[ahmi_pkg::FACTOR_W-1:0];
                default: ;
            endcase
        end
    end

    // A word is taken only when every lane has finished with the last one.
    assign i_smp.ready = lane_stat[0].idle && lane_stat[1].idle && lane_stat[2].idle;
    assign accept      = i_smp.valid && i_smp.ready;

    assign lane_ctrl.start = accept;
    assign lane_ctrl.ack   = ack;

    assign lane_sample[0] = i_smp.sample_x;
    assign lane_sample[1] = i_smp.sample_y;
    assign lane_sample[2] = i_smp.sample_z;

    for (genvar g = 0; g < ahmi_pkg::AXES; g++) begin : g_lane
        ahmi_lane #(
            .FRAC_BITS   (FRAC_BITS),
            .STATE_WIDTH (STATE_WIDTH)
        ) u_lane (
            .i_clk       (i_clk),
            .i_rst_n     (i_rst_n),
            .i_ctrl      (lane_ctrl),
            .i_sample    (lane_sample[g]),
            .i_deadband  (r_deadband),
            .i_gain      (r_gain),
            .i_damping   (r_damping),
            .i_retention (r_retention),
            .o_stat      (lane_stat[g]),
            .o_pos       (lane_pos[g])
        );
    end

    ahmi_merge #(
        .STATE_WIDTH (STATE_WIDTH)
    ) u_merge (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_stat  (lane_stat),
        .i_pos   (lane_pos),
        .o_ack   (ack),
        .o_res   (o_res)
    );

endmodule

`default_nettype wire

[hdl/ahmi_checker.sv]
// Port-level checks of the hand motion integrator, bound to the top level.
// Uses the assertion macros of accel_hand_motion_integrator_defines.svh.
`default_nettype none

`include "accel_hand_motion_integrator_defines.svh"

module ahmi_checker #(
    parameter int STATE_WIDTH = 40
) (
    input wire logic                           i_clk,
    input wire logic                           i_rst_n,
    input wire logic                           i_in_valid,
    input wire logic                           i_in_ready,
    input wire logic                           i_out_valid,
    input wire logic                           i_out_ready,
    input wire logic signed [STATE_WIDTH-1:0]  i_pos_x
);

    // A waiting result word is not dropped, and its x position does not change.
    `AHMI_ASSERT_HOLD(a_out_hold, i_clk, i_rst_n, i_out_valid && !i_out_ready, {i_out_valid, i_pos_x})

    // Only one word is in the lanes at a time.
    `AHMI_ASSERT(a_busy_after_accept, i_clk, i_rst_n, i_in_valid && i_in_ready |=> !i_in_ready)

    // Accepting a word never raises the result valid flag at once.
    `AHMI_ASSERT(a_no_instant_result, i_clk, i_rst_n, i_in_valid && i_in_ready |=> !$rose(i_out_valid))

    // A new result appears only when the lanes had a word in flight.
    `AHMI_ASSERT(a_result_from_work, i_clk, i_rst_n, $rose(i_out_valid) |-> $past(!i_in_ready))

endmodule

bind accel_hand_motion_integrator ahmi_checker #(
    .STATE_WIDTH (STATE_WIDTH)
) u_ahmi_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_smp.valid),
    .i_in_ready  (i_smp.ready),
    .i_out_valid (o_res.valid),
    .i_out_ready (o_res.ready),
    .i_pos_x     (o_res.pos_x)
);

`default_nettype wire
